>>> sv/windowed_flow_threshold_monitor_top_defines.svh
// Assertion macros for the checker file of the flow threshold monitor.
`ifndef WINDOWED_FLOW_THRESHOLD_MONITOR_TOP_DEFINES_SVH
`define WINDOWED_FLOW_THRESHOLD_MONITOR_TOP_DEFINES_SVH

// Property checked on every clock edge outside of reset.
`define WFTM_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("flow monitor check failed in %m");

// Property that also holds while reset is asserted.
`define WFTM_ASSERT_RST(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("flow monitor reset check failed in %m");

`endif

>>> sv/wftm_pkg.sv
package wftm_pkg;

   // Ring geometry.
   localparam int SLOTS = 4;
   localparam int PTR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Field widths.
   localparam int CNT_DATA_W = 32;
   localparam int SLOT_W = 2 * CNT_DATA_W;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_DATA_W-1:0] MIN_WINDOW_MS = 32'd3000;

   // Configuration register indexes.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_PACKET_THRESHOLD = 3'd0,
      CSR_BYTE_THRESHOLD   = 3'd1,
      CSR_USE_PACKETS      = 3'd2,
      CSR_USE_BYTES        = 3'd3,
      CSR_AT_OR_ABOVE      = 3'd4,
      CSR_AT_OR_BELOW      = 3'd5,
      CSR_WINDOW_MS        = 3'd6
   } csr_index_type;

   // Controller states.
   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_UPDATE = 4'b0010,
      ST_SUM    = 4'b0100,
      ST_EVAL   = 4'b1000
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_in;
      logic update;
      logic sum_step;
      logic eval_load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic sum_done;
      logic out_busy;
   } stat_type;

endpackage

>>> sv/wftm_ram.sv
module wftm_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 4
) (
   input  logic                                       clock,
   input  logic                                       we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                           wdata,
   input  logic                                       re,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                           rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port, one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/wftm_ctrl.sv
module wftm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  wftm_pkg::stat_type stat,
   output wftm_pkg::cmd_type  cmd
);

   wftm_pkg::state_type state_ff, state_in;

   // Sequencer: take a word, update the ring, sum it, then publish the result.
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         wftm_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in = wftm_pkg::ST_UPDATE;
            end
         end
         wftm_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = wftm_pkg::ST_SUM;
         end
         wftm_pkg::ST_SUM: begin
            if (stat.sum_done) begin
               state_in = wftm_pkg::ST_EVAL;
            end else begin
               cmd.sum_step = 1'b1;
            end
         end
         wftm_pkg::ST_EVAL: begin
            if (!stat.out_busy) begin
               cmd.eval_load = 1'b1;
               state_in = wftm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wftm_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wftm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == wftm_pkg::ST_IDLE);

endmodule

>>> sv/wftm_dp.sv
module wftm_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  wftm_pkg::cmd_type                     cmd,
   output wftm_pkg::stat_type                    stat,
   input  logic [wftm_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [wftm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [wftm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [wftm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int W = wftm_pkg::CNT_DATA_W;

   // Configuration registers.
   logic [W-1:0] packet_threshold_ff, byte_threshold_ff, window_ms_ff;
   logic         use_packets_ff, use_bytes_ff, at_or_above_ff, at_or_below_ff;

   // Captured input word.
   logic [W-1:0] pk_ff, by_ff;
   logic         ok_ff;

   // Tick state.
   logic [W-1:0]                 prev_packets_ff, prev_bytes_ff;
   logic                         baseline_ff, wrapped_ff, skipped_ff;
   logic [wftm_pkg::PTR_W-1:0]   ptr_ff;

   // Window summation.
   logic [wftm_pkg::CNT_W-1:0]   idx_ff, count;
   logic                         pend_ff, issue;
   logic [W-1:0]                 acc_p_ff, acc_b_ff;
   logic [wftm_pkg::SLOT_W-1:0]  rd_data, wr_data;
   logic                         wr_en, dec;

   // Result register.
   logic                         rsp_valid_ff;
   logic [wftm_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                         bad, fire, hit_p, hit_b;

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         packet_threshold_ff <= '0;
         byte_threshold_ff   <= '0;
         use_packets_ff      <= 1'b0;
         use_bytes_ff        <= 1'b0;
         at_or_above_ff      <= 1'b0;
         at_or_below_ff      <= 1'b0;
         window_ms_ff        <= wftm_pkg::MIN_WINDOW_MS;
      end else if (csr_we) begin
         case (csr_addr)
            wftm_pkg::CSR_PACKET_THRESHOLD: packet_threshold_ff <= csr_wdata;
            wftm_pkg::CSR_BYTE_THRESHOLD:   byte_threshold_ff <= csr_wdata;
            wftm_pkg::CSR_USE_PACKETS:      use_packets_ff <= csr_wdata[0];
            wftm_pkg::CSR_USE_BYTES:        use_bytes_ff <= csr_wdata[0];
            wftm_pkg::CSR_AT_OR_ABOVE:      at_or_above_ff <= csr_wdata[0];
            wftm_pkg::CSR_AT_OR_BELOW:      at_or_below_ff <= csr_wdata[0];
            wftm_pkg::CSR_WINDOW_MS:        window_ms_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Input capture.
   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         pk_ff <= req_tdata[W-1:0];
         by_ff <= req_tdata[2*W-1:W];
         ok_ff <= req_tuser;
      end
   end

   // A counter that is tested and went backwards voids the tick.
   assign dec = (use_packets_ff && (prev_packets_ff > pk_ff)) ||
                (use_bytes_ff && (prev_bytes_ff > by_ff));

   assign wr_en   = cmd.update && ok_ff && baseline_ff;
   assign wr_data = dec ? '0 : {by_ff - prev_bytes_ff, pk_ff - prev_packets_ff};

   // Baseline, previous counters, ring pointer and wrap flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_packets_ff <= '0;
         prev_bytes_ff   <= '0;
         baseline_ff     <= 1'b0;
         ptr_ff          <= '0;
         wrapped_ff      <= 1'b0;
         skipped_ff      <= 1'b1;
      end else if (cmd.update) begin
         skipped_ff <= 1'b1;
         if (ok_ff) begin
            prev_packets_ff <= pk_ff;
            prev_bytes_ff   <= by_ff;
            baseline_ff     <= 1'b1;
            if (baseline_ff && !dec) begin
               skipped_ff <= 1'b0;
               if (ptr_ff == wftm_pkg::PTR_W'(wftm_pkg::SLOTS - 1)) begin
                  ptr_ff     <= '0;
                  wrapped_ff <= 1'b1;
               end else begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
            end
         end
      end
   end

   // Slot storage: packet delta in the low half, byte delta in the high half.
   wftm_ram #(
      .WIDTH (wftm_pkg::SLOT_W),
      .DEPTH (wftm_pkg::SLOTS)
   ) u_slots (
      .clock (clock),
      .we    (wr_en),
      .waddr (ptr_ff),
      .wdata (wr_data),
      .re    (issue),
      .raddr (idx_ff[wftm_pkg::PTR_W-1:0]),
      .rdata (rd_data)
   );

   // Slots summed: all once wrapped, else those below the pointer.
   assign count = wrapped_ff ? wftm_pkg::CNT_W'(wftm_pkg::SLOTS)
                             : wftm_pkg::CNT_W'(ptr_ff);
   assign issue = cmd.sum_step && (idx_ff < count);

   // One slot read per cycle, accumulated in the cycle after its read.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else if (cmd.update) begin
         idx_ff  <= '0;
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= issue;
         if (issue) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         acc_p_ff <= '0;
         acc_b_ff <= '0;
      end else if (pend_ff) begin
         acc_p_ff <= acc_p_ff + rd_data[W-1:0];
         acc_b_ff <= acc_b_ff + rd_data[2*W-1:W];
      end
   end

   assign stat.sum_done = (idx_ff >= count) && !pend_ff;
   assign stat.out_busy = rsp_valid_ff && !rsp_tready;

   // Threshold tests on the finished sums.
   assign bad = !(use_packets_ff || use_bytes_ff) ||
                !(at_or_above_ff ^ at_or_below_ff) ||
                (window_ms_ff < wftm_pkg::MIN_WINDOW_MS);
   assign hit_p = (at_or_above_ff && (acc_p_ff >= packet_threshold_ff)) ||
                  (at_or_below_ff && wrapped_ff && (acc_p_ff <= packet_threshold_ff));
   assign hit_b = (at_or_above_ff && (acc_b_ff >= byte_threshold_ff)) ||
                  (at_or_below_ff && wrapped_ff && (acc_b_ff <= byte_threshold_ff));
   assign fire  = !skipped_ff && !bad &&
                  ((use_packets_ff && hit_p) || (use_bytes_ff && hit_b));

   // Output register holds the word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.eval_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval_load) begin
         rsp_data_ff <= {4'b0000, skipped_ff, bad, wrapped_ff, acc_b_ff, acc_p_ff, fire};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/windowed_flow_threshold_monitor_top.sv
// Windowed flow threshold monitor.
// The req channel brings one word per tick: the cumulative packet and byte
// counters of one flow in tdata and the read-succeeded flag in tuser. For each
// word the rsp channel returns exactly one word with the fire flag, the
// packet and byte sums over the window, the window-full, bad-settings and
// tick-skipped flags. The csr port writes the thresholds, test enables, mode
// bits and window length; write it only while no word is in flight.
// One word is worked on at a time. It is captured at acceptance, then the ring
// is updated, the slots are summed through the single read port of the slot
// memory, and the result is evaluated. The next word is taken as soon as the
// previous result is loaded into the output register.
// If the receiver stalls, the result waits in the output register; a new word
// is taken and summed meanwhile, and waits to evaluate until that register is free.
// Synchronous reset clears the baseline, ring pointer and wrap flag and loads
// the register defaults; the slot memory needs no clearing.
module windowed_flow_threshold_monitor_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: packet_total[31:0], byte_total[63:32].
   input  logic [wftm_pkg::REQ_DATA_W-1:0]       req_tdata,
   // Fields from bit 0: read_ok.
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from bit 0: fire[0], window_packets[32:1], window_bytes[64:33],
   // window_full[65], settings_bad[66], tick_skipped[67], zero fill above.
   output logic [wftm_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   input  logic                                  csr_we,
   input  logic [wftm_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [wftm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   wftm_pkg::cmd_type  cmd;
   wftm_pkg::stat_type stat;

   wftm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wftm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule

>>> sv/wftm_checker.sv
`include "windowed_flow_threshold_monitor_top_defines.svh"

module wftm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_tvalid,
   input logic                                  req_tready,
   input logic                                  rsp_tvalid,
   input logic                                  rsp_tready,
   input logic [wftm_pkg::RSP_DATA_W-1:0]       rsp_tdata
);

   // No result word is offered right after reset.
   `WFTM_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_tvalid)

   // A stalled result word stays offered and unchanged.
   `WFTM_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))

   // Words are worked one at a time: no second word is taken in the next cycle.
   `WFTM_ASSERT(a_one_word_in_flight, req_tvalid && req_tready |=> !req_tready)

   // Fire is never raised on a skipped tick or with bad settings.
   `WFTM_ASSERT(a_fire_gated, rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[66] && !rsp_tdata[67])

endmodule

bind windowed_flow_threshold_monitor_top wftm_checker u_wftm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
